// ----- hw/rtl/svm_pkg.sv -----
// ---------------------------------------------------------------------------
// svm_pkg
// Shared types and codes of the script VM execute unit.
// ---------------------------------------------------------------------------
`default_nettype none
package svm_pkg;

  localparam int unsigned CmdW    = 5;
  localparam int unsigned StatusW = 3;
  localparam int unsigned WaitW   = 3;
  localparam int unsigned CodeLenW = 21;
  localparam int unsigned ImmSW   = 12;
  localparam int unsigned ImmLW   = 20;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned OutPcW  = 20;
  localparam logic [CodeLenW-1:0] CodeLenReset = 21'd1024;

  typedef enum logic [CmdW-1:0] {
    CmdNop = 5'd0, CmdHalt = 5'd1, CmdFail = 5'd2, CmdYield = 5'd3,
    CmdTYield = 5'd4, CmdJump = 5'd5, CmdJumpIf = 5'd6, CmdJumpIfNot = 5'd7,
    CmdWaitColl = 5'd8, CmdWaitMove = 5'd9, CmdWaitGround = 5'd10,
    CmdWaitAnim = 5'd11, CmdLoadConst = 5'd12, CmdLoadHigh = 5'd13,
    CmdMove = 5'd14, CmdAdd = 5'd15, CmdSub = 5'd16, CmdMul = 5'd17,
    CmdDiv = 5'd18, CmdMod = 5'd19, CmdAddImm = 5'd20, CmdEq = 5'd21,
    CmdNe = 5'd22, CmdLt = 5'd23, CmdLe = 5'd24, CmdGt = 5'd25, CmdGe = 5'd26
  } cmd_e;

  localparam logic [StatusW-1:0] StRun = 3'd0, StDone = 3'd1, StFail = 3'd2,
    StYield = 3'd3, StWait = 3'd4, StUnsup = 3'd5;
  localparam logic [WaitW-1:0] WkNone = 3'd0, WkFrames = 3'd1, WkTimer = 3'd2,
    WkColl = 3'd3, WkMove = 3'd4, WkGround = 3'd5;
  localparam logic [31:0] AnimTimer = 32'd100;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch input item and operands
    logic exec;      // run non-iterative op, load result register
    logic div_start; // begin iterative divide
    logic div_step;  // one quotient bit
    logic div_fin;   // load divide result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_div;
    logic div_last;
  } dp_sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/svm_if.sv -----
// ---------------------------------------------------------------------------
// svm_in_if / svm_out_if
// Ready/valid channels for instructions and results.
// ---------------------------------------------------------------------------
`default_nettype none
interface svm_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  command;
  logic [3:0]  dst;
  logic [3:0]  src_a;
  logic [3:0]  src_b;
  logic [11:0] imm_short;
  logic [19:0] imm_long;
  modport source (output valid, command, dst, src_a, src_b, imm_short, imm_long,
                  input ready);
  modport sink (input valid, command, dst, src_a, src_b, imm_short, imm_long,
                output ready);
endinterface

interface svm_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [19:0]        next_pc;
  logic [2:0]         wait_kind;
  logic signed [31:0] wait_value;
  logic               write_enable;
  logic [3:0]         written_reg;
  logic signed [31:0] write_value;
  modport source (output valid, status, next_pc, wait_kind, wait_value,
                  write_enable, written_reg, write_value, input ready);
  modport sink (input valid, status, next_pc, wait_kind, wait_value,
                write_enable, written_reg, write_value, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/svm_ctrl.sv -----
// ---------------------------------------------------------------------------
// svm_ctrl
// Sequencer: take a beat, execute or iterate the divider, present result.
// ---------------------------------------------------------------------------
`default_nettype none
module svm_ctrl
  import svm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t   cmd_o
);
  typedef enum logic [3:0] {
    SIdle = 4'b0001, SExec = 4'b0010, SDiv = 4'b0100, SOut = 4'b1000
  } state_e;
  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = SExec;
        end
      end
      SExec: begin
        if (sts_i.is_div) begin
          cmd_o.div_start = 1'b1;
          state_d = SDiv;
        end else begin
          cmd_o.exec = 1'b1;
          state_d = SOut;
        end
      end
      SDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          cmd_o.div_fin = 1'b1;
          state_d = SOut;
        end
      end
      SOut: begin
        out_valid_o = 1'b1;
        in_ready_o = out_ready_i;
        if (out_ready_i) begin
          if (in_valid_i) begin
            cmd_o.capture = 1'b1;
            state_d = SExec;
          end else begin
            state_d = SIdle;
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= SIdle;
    else state_q <= state_d;
  end
endmodule
`default_nettype wire

// ----- hw/rtl/svm_dpath.sv -----
// ---------------------------------------------------------------------------
// svm_dpath
// Register file, program counter, ALU and a radix-2 restoring divider.
// ---------------------------------------------------------------------------
`default_nettype none
module svm_dpath
  import svm_pkg::*;
#(
  parameter int unsigned NUM_REGS = 16,
  parameter int unsigned PC_BITS  = 20
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire dp_cmd_t             cmd_i,
  output dp_sts_t                  sts_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CodeLenW-1:0] cfg_data_i,
  input  wire logic [CmdW-1:0]     command_i,
  input  wire logic [IdxW-1:0]     dst_i,
  input  wire logic [IdxW-1:0]     src_a_i,
  input  wire logic [IdxW-1:0]     src_b_i,
  input  wire logic [ImmSW-1:0]    imm_short_i,
  input  wire logic [ImmLW-1:0]    imm_long_i,
  output logic [StatusW-1:0]       status_o,
  output logic [OutPcW-1:0]        next_pc_o,
  output logic [WaitW-1:0]         wait_kind_o,
  output logic [31:0]              wait_value_o,
  output logic                     write_enable_o,
  output logic [IdxW-1:0]          written_reg_o,
  output logic [31:0]              write_value_o
);
  localparam int unsigned RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int unsigned PW = (PC_BITS > CodeLenW) ? PC_BITS : CodeLenW;

  logic [31:0] rf_q [NUM_REGS];
  logic [PC_BITS-1:0] pc_q, pc_d;
  logic [CodeLenW-1:0] code_len_q;

  cmd_e cmd_q;
  logic [RW-1:0] d_q;
  logic [IdxW-1:0] dout_q;
  logic [ImmSW-1:0] is_q;
  logic [ImmLW-1:0] il_q;
  logic [31:0] va_q, vb_q, vd_q;

  // divider
  logic [31:0] dq_q, dr_q, dm_q;
  logic [4:0] dcnt_q;
  logic dnq_q, dnr_q, dz_q;
  logic [32:0] trial;

  // fold the index into the register count by repeated subtraction
  function automatic logic [RW-1:0] ridx(logic [IdxW-1:0] i);
    logic [7:0] w;
    w = {4'd0, i};
    for (int k = 0; k < 4; k++) begin
      if (w >= 8'(NUM_REGS)) w = w - 8'(NUM_REGS);
    end
    return RW'(w);
  endfunction

  logic in_range;
  assign in_range = {{(PW-PC_BITS){1'b0}}, pc_q} < {{(PW-CodeLenW){1'b0}}, code_len_q};
  assign sts_o.is_div = in_range && (cmd_q == CmdDiv || cmd_q == CmdMod);
  assign sts_o.div_last = (dcnt_q == 5'd0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q <= cmd_e'(command_i);
      d_q <= ridx(dst_i);
      dout_q <= IdxW'(ridx(dst_i));
      is_q <= imm_short_i;
      il_q <= imm_long_i;
      va_q <= rf_q[ridx(src_a_i)];
      vb_q <= rf_q[ridx(src_b_i)];
      vd_q <= rf_q[ridx(dst_i)];
    end
  end

  // results
  logic [StatusW-1:0] st;
  logic [WaitW-1:0] wk;
  logic [31:0] wv, res;
  logic we;
  logic [31:0] prod;
  logic lt_ab, lt_ba;

  assign prod = va_q * vb_q;
  assign lt_ab = $signed(va_q) < $signed(vb_q);
  assign lt_ba = $signed(vb_q) < $signed(va_q);

  always_comb begin
    st = StRun; wk = WkNone; wv = '0; res = '0; we = 1'b0;
    pc_d = pc_q + PC_BITS'(1);
    if (!in_range) begin
      st = StDone;
      pc_d = pc_q;
    end else begin
      unique case (cmd_q)
        CmdNop: ;
        CmdHalt: st = StDone;
        CmdFail: st = StFail;
        CmdYield: begin
          st = StYield; wk = WkFrames;
          wv = (is_q == '0) ? 32'd1 : 32'(is_q);
        end
        CmdTYield: begin
          st = StWait; wk = WkTimer; wv = 32'($signed(il_q));
        end
        CmdJump: pc_d = PC_BITS'({{(PW+32){1'b0}}, il_q});
        CmdJumpIf: if (va_q != '0) pc_d = PC_BITS'({{(PW+32){1'b0}}, is_q});
        CmdJumpIfNot: if (va_q == '0) pc_d = PC_BITS'({{(PW+32){1'b0}}, is_q});
        CmdWaitColl: begin st = StWait; wk = WkColl; wv = va_q; end
        CmdWaitMove: begin st = StWait; wk = WkMove; wv = va_q; end
        CmdWaitGround: begin st = StWait; wk = WkGround; wv = va_q; end
        CmdWaitAnim: begin st = StWait; wk = WkTimer; wv = AnimTimer; end
        CmdLoadConst: begin we = 1'b1; res = 32'($signed(il_q)); end
        CmdLoadHigh: begin we = 1'b1; res = {is_q, vd_q[19:0]}; end
        CmdMove: begin we = 1'b1; res = va_q; end
        CmdAdd: begin we = 1'b1; res = va_q + vb_q; end
        CmdSub: begin we = 1'b1; res = va_q - vb_q; end
        CmdMul: begin we = 1'b1; res = prod; end
        CmdDiv, CmdMod: we = 1'b1;
        CmdAddImm: begin we = 1'b1; res = va_q + 32'($signed(is_q)); end
        CmdEq: begin we = 1'b1; res = 32'(va_q == vb_q); end
        CmdNe: begin we = 1'b1; res = 32'(va_q != vb_q); end
        CmdLt: begin we = 1'b1; res = 32'(lt_ab); end
        CmdLe: begin we = 1'b1; res = 32'(!lt_ba); end
        CmdGt: begin we = 1'b1; res = 32'(lt_ba); end
        CmdGe: begin we = 1'b1; res = 32'(!lt_ab); end
        default: st = StUnsup;
      endcase
    end
  end

  assign trial = {dr_q, dq_q[31]} - {1'b0, dm_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dq_q <= va_q[31] ? -va_q : va_q;
      dm_q <= vb_q[31] ? -vb_q : vb_q;
      dr_q <= '0;
      dnq_q <= va_q[31] ^ vb_q[31];
      dnr_q <= va_q[31];
      dz_q <= (vb_q == '0);
      dcnt_q <= 5'd31;
    end else if (cmd_i.div_step) begin
      if (!trial[32]) begin
        dr_q <= trial[31:0];
        dq_q <= {dq_q[30:0], 1'b1};
      end else begin
        dr_q <= {dr_q[30:0], dq_q[31]};
        dq_q <= {dq_q[30:0], 1'b0};
      end
      dcnt_q <= dcnt_q - 5'd1;
    end
  end

  // quotient/remainder on final step, combinational from trial
  logic [31:0] fq, fr, fq_s, fr_s, fres;
  assign fq = {dq_q[30:0], !trial[32]};
  assign fr = trial[32] ? {dr_q[30:0], dq_q[31]} : trial[31:0];
  assign fq_s = dnq_q ? -fq : fq;
  assign fr_s = dnr_q ? -fr : fr;
  assign fres = dz_q ? '0 : ((cmd_q == CmdDiv) ? fq_s : fr_s);

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec || cmd_i.div_start) begin
      status_o <= st;
      next_pc_o <= OutPcW'({{(PW+32){1'b0}}, pc_d});
      wait_kind_o <= wk;
      wait_value_o <= wv;
      write_enable_o <= we;
      written_reg_o <= we ? dout_q : '0;
      write_value_o <= res;
    end else if (cmd_i.div_fin) begin
      write_value_o <= fres;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
      code_len_q <= CodeLenReset;
      for (int i = 0; i < NUM_REGS; i++) rf_q[i] <= '0;
    end else begin
      if (cfg_we_i) code_len_q <= cfg_data_i;
      if (cmd_i.exec || cmd_i.div_start) pc_q <= pc_d;
      if (cmd_i.exec && we) rf_q[d_q] <= res;
      if (cmd_i.div_fin) rf_q[d_q] <= fres;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/script_vm_execute_unit.sv -----
// ---------------------------------------------------------------------------
// script_vm_execute_unit
// Executes one decoded bytecode instruction per beat.
// ---------------------------------------------------------------------------
// An instruction beat is captured on acceptance, executed in SExec and presented
// from SOut for every operation except an in-range divide or modulo, which
// first iterates a radix-2 restoring divider in SDiv. One instruction is in flight
// at a time; the next beat is taken in the same cycle the result beat leaves.
`default_nettype none
module script_vm_execute_unit
  import svm_pkg::*;
#(
  parameter int unsigned NUM_REGS = 16,
  parameter int unsigned PC_BITS  = 20
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CodeLenW-1:0] cfg_data_i,
  svm_in_if.sink                   in_if,
  svm_out_if.source                out_if
);
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [31:0] wv, wr;

  svm_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid), .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  svm_dpath #(.NUM_REGS(NUM_REGS), .PC_BITS(PC_BITS)) u_dpath (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .cfg_we_i, .cfg_data_i,
    .command_i(in_if.command), .dst_i(in_if.dst), .src_a_i(in_if.src_a),
    .src_b_i(in_if.src_b), .imm_short_i(in_if.imm_short),
    .imm_long_i(in_if.imm_long),
    .status_o(out_if.status), .next_pc_o(out_if.next_pc),
    .wait_kind_o(out_if.wait_kind), .wait_value_o(wv),
    .write_enable_o(out_if.write_enable), .written_reg_o(out_if.written_reg),
    .write_value_o(wr)
  );

  assign out_if.wait_value = wv;
  assign out_if.write_value = wr;
endmodule
`default_nettype wire

// ----- verif/script_vm_execute_unit_tb.sv -----
// ---------------------------------------------------------------------------
// script_vm_execute_unit_tb
// Drives decoded instructions into the execute unit, in some phases with random
// idling on both channels, predicts each result beat from a private copy of the
// register file, program counter and program length, and checks every field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module script_vm_execute_unit_tb;
  import svm_pkg::*;

  typedef struct packed {
    logic [4:0]  command;
    logic [3:0]  dst;
    logic [3:0]  src_a;
    logic [3:0]  src_b;
    logic [11:0] imm_short;
    logic [19:0] imm_long;
  } instr_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [19:0] next_pc;
    logic [2:0]  wait_kind;
    logic [31:0] wait_value;
    logic        write_enable;
    logic [3:0]  written_reg;
    logic [31:0] write_value;
  } outcome_t;

  class vm_scoreboard;
    logic [31:0] regs [16];
    logic [19:0] pc;
    logic [20:0] code_len;
    outcome_t    pending[$];
    int          errors;
    int          checked;

    function new();
      foreach (regs[i]) regs[i] = '0;
      pc = '0;
      code_len = CodeLenReset;
      errors = 0;
      checked = 0;
    endfunction

    function logic [31:0] mag(logic [31:0] v);
      return v[31] ? -v : v;
    endfunction

    function logic slt(logic [31:0] a, logic [31:0] b);
      return $signed(a) < $signed(b);
    endfunction

    function void note_instr(instr_t it);
      outcome_t    o;
      logic [31:0] va, vb, res, q;
      logic        we;
      va = regs[it.src_a];
      vb = regs[it.src_b];
      o = '0;
      res = '0;
      we = 1'b0;
      if ({11'd0, pc} >= {11'd0, code_len}) begin
        o.status = StDone;
      end else begin
        pc = pc + 20'd1;
        we = 1'b1;
        case (it.command)
          CmdNop: we = 1'b0;
          CmdHalt: begin we = 1'b0; o.status = StDone; end
          CmdFail: begin we = 1'b0; o.status = StFail; end
          CmdYield: begin
            we = 1'b0; o.status = StYield; o.wait_kind = WkFrames;
            o.wait_value = (it.imm_short == 0) ? 32'd1 : {20'd0, it.imm_short};
          end
          CmdTYield: begin
            we = 1'b0; o.status = StWait; o.wait_kind = WkTimer;
            o.wait_value = {{12{it.imm_long[19]}}, it.imm_long};
          end
          CmdJump: begin we = 1'b0; pc = it.imm_long; end
          CmdJumpIf: begin we = 1'b0; if (va != 0) pc = {8'd0, it.imm_short}; end
          CmdJumpIfNot: begin we = 1'b0; if (va == 0) pc = {8'd0, it.imm_short}; end
          CmdWaitColl: begin
            we = 1'b0; o.status = StWait; o.wait_kind = WkColl; o.wait_value = va;
          end
          CmdWaitMove: begin
            we = 1'b0; o.status = StWait; o.wait_kind = WkMove; o.wait_value = va;
          end
          CmdWaitGround: begin
            we = 1'b0; o.status = StWait; o.wait_kind = WkGround; o.wait_value = va;
          end
          CmdWaitAnim: begin
            we = 1'b0; o.status = StWait; o.wait_kind = WkTimer;
            o.wait_value = AnimTimer;
          end
          CmdLoadConst: res = {{12{it.imm_long[19]}}, it.imm_long};
          CmdLoadHigh: res = {it.imm_short, regs[it.dst][19:0]};
          CmdMove: res = va;
          CmdAdd: res = va + vb;
          CmdSub: res = va - vb;
          CmdMul: res = va * vb;
          CmdDiv: begin
            q = (vb == 0) ? 32'd0 : mag(va) / mag(vb);
            res = (vb != 0 && (va[31] ^ vb[31])) ? -q : q;
          end
          CmdMod: begin
            q = (vb == 0) ? 32'd0 : mag(va) % mag(vb);
            res = va[31] ? -q : q;
          end
          CmdAddImm: res = va + {{20{it.imm_short[11]}}, it.imm_short};
          CmdEq: res = {31'd0, va == vb};
          CmdNe: res = {31'd0, va != vb};
          CmdLt: res = {31'd0, slt(va, vb)};
          CmdLe: res = {31'd0, !slt(vb, va)};
          CmdGt: res = {31'd0, slt(vb, va)};
          CmdGe: res = {31'd0, !slt(va, vb)};
          default: begin we = 1'b0; o.status = StUnsup; end
        endcase
        if (we) regs[it.dst] = res;
      end
      o.next_pc = pc;
      o.write_enable = we;
      o.written_reg = we ? it.dst : 4'd0;
      o.write_value = we ? res : 32'd0;
      pending.push_back(o);
    endfunction

    function void check_result(outcome_t got);
      outcome_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("result beat with no instruction outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status); errors++;
      end
      if (got.next_pc !== e.next_pc) begin
        $error("next_pc exp %0h got %0h", e.next_pc, got.next_pc); errors++;
      end
      if (got.wait_kind !== e.wait_kind) begin
        $error("wait_kind exp %0d got %0d", e.wait_kind, got.wait_kind); errors++;
      end
      if (got.wait_value !== e.wait_value) begin
        $error("wait_value exp %0h got %0h", e.wait_value, got.wait_value); errors++;
      end
      if (got.write_enable !== e.write_enable) begin
        $error("write_enable exp %0d got %0d", e.write_enable, got.write_enable);
        errors++;
      end
      if (got.written_reg !== e.written_reg) begin
        $error("written_reg exp %0d got %0d", e.written_reg, got.written_reg); errors++;
      end
      if (got.write_value !== e.write_value) begin
        $error("write_value exp %0h got %0h", e.write_value, got.write_value); errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [20:0] cfg_data_i;
  svm_in_if    in_ch();
  svm_out_if   out_ch();

  vm_scoreboard sb;
  bit          idle_on;
  bit          hold_out;
  int          sent;
  longint      cycles;

  script_vm_execute_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch.sink),
    .out_if     (out_ch.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 400000) begin
        $display("script_vm_execute_unit_tb NOT OK");
        $finish;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.status, out_ch.next_pc, out_ch.wait_kind,
                       out_ch.wait_value, out_ch.write_enable, out_ch.written_reg,
                       out_ch.write_value});
  end

  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_out) begin
        out_ch.ready <= 1'b0;
        @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 9);
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_instr(instr_t it);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= it.command;
    in_ch.dst       <= it.dst;
    in_ch.src_a     <= it.src_a;
    in_ch.src_b     <= it.src_b;
    in_ch.imm_short <= it.imm_short;
    in_ch.imm_long  <= it.imm_long;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_instr(it);
    sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_code_len(logic [20:0] len);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= len;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.code_len = len;
  endtask

  function automatic instr_t mk(logic [4:0] c, logic [3:0] d, logic [3:0] a,
                                logic [3:0] b, logic [11:0] s, logic [19:0] l);
    return '{c, d, a, b, s, l};
  endfunction

  function automatic instr_t rand_instr();
    instr_t it;
    it.dst       = 4'($urandom);
    it.src_a     = 4'($urandom);
    it.src_b     = 4'($urandom);
    it.imm_short = 12'($urandom);
    it.imm_long  = 20'($urandom);
    if ($urandom_range(0, 9) == 0)
      it.command = 5'($urandom_range(27, 31));
    else if ($urandom_range(0, 3) == 0)
      it.command = 5'($urandom_range(CmdLoadConst, CmdGe));
    else
      it.command = 5'($urandom_range(0, 26));
    // keep branches mostly inside a short program
    if (it.command == CmdJump && $urandom_range(0, 3) != 0)
      it.imm_long = 20'($urandom_range(0, 60));
    if (it.command == CmdHalt && $urandom_range(0, 1)) it.command = CmdAdd;
    return it;
  endfunction

  task automatic rand_phase(int n);
    instr_t it;
    repeat (n) begin
      it = rand_instr();
      if (sb.pc >= sb.code_len && $urandom_range(0, 3) != 0)
        it = mk(CmdJump, 0, 0, 0, 0, 20'($urandom_range(0, 20)));
      send_instr(it);
    end
  endtask

  initial begin
    sb = new();
    idle_on = 1'b0;
    hold_out = 1'b0;
    sent = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.command = '0;
    in_ch.dst = '0;
    in_ch.src_a = '0;
    in_ch.src_b = '0;
    in_ch.imm_short = '0;
    in_ch.imm_long = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_instr(mk(CmdLoadConst, 1, 0, 0, 0, 20'h80000));
    send_instr(mk(CmdLoadHigh, 1, 0, 0, 12'h800, 0));
    send_instr(mk(CmdLoadConst, 2, 0, 0, 0, 20'hFFFFF));
    send_instr(mk(CmdDiv, 3, 1, 2, 0, 0));
    send_instr(mk(CmdMod, 4, 1, 2, 0, 0));
    send_instr(mk(CmdDiv, 5, 2, 0, 0, 0));
    send_instr(mk(CmdMod, 5, 1, 0, 0, 0));
    send_instr(mk(CmdLoadConst, 6, 0, 0, 0, 20'h7FFFF));
    send_instr(mk(CmdMul, 7, 6, 6, 0, 0));
    send_instr(mk(CmdAdd, 8, 6, 1, 0, 0));
    send_instr(mk(CmdSub, 9, 1, 6, 0, 0));
    send_instr(mk(CmdAddImm, 10, 1, 0, 12'hFFF, 0));
    send_instr(mk(CmdMove, 15, 1, 0, 0, 0));
    for (int c = CmdEq; c <= CmdGe; c++) send_instr(mk(5'(c), 11, 1, 6, 0, 0));
    send_instr(mk(CmdYield, 0, 0, 0, 0, 0));
    send_instr(mk(CmdYield, 0, 0, 0, 12'hFFF, 0));
    send_instr(mk(CmdTYield, 0, 0, 0, 0, 20'h80000));
    send_instr(mk(CmdWaitColl, 0, 1, 0, 0, 0));
    send_instr(mk(CmdWaitMove, 0, 6, 0, 0, 0));
    send_instr(mk(CmdWaitGround, 0, 2, 0, 0, 0));
    send_instr(mk(CmdWaitAnim, 0, 0, 0, 0, 0));
    send_instr(mk(CmdJumpIf, 0, 1, 0, 12'd3, 0));
    send_instr(mk(CmdJumpIfNot, 0, 0, 0, 12'hFFF, 0));
    send_instr(mk(CmdFail, 0, 0, 0, 0, 0));
    send_instr(mk(5'd31, 0, 0, 0, 0, 0));
    send_instr(mk(CmdJump, 0, 0, 0, 0, 20'hFFFFF));
    send_instr(mk(CmdNop, 0, 0, 0, 0, 0));
    send_instr(mk(CmdNop, 0, 0, 0, 0, 0));
    drain();

    set_code_len(21'h1FFFFF);
    send_instr(mk(CmdJump, 0, 0, 0, 0, 20'hFFFFF));
    send_instr(mk(CmdNop, 0, 0, 0, 0, 0));
    send_instr(mk(CmdHalt, 0, 0, 0, 0, 0));
    drain();

    set_code_len(21'd1);
    send_instr(mk(CmdJump, 0, 0, 0, 0, 0));
    send_instr(mk(CmdNop, 0, 0, 0, 0, 0));
    send_instr(mk(CmdAdd, 1, 1, 1, 0, 0));
    drain();

    idle_on = 1'b1;
    set_code_len(21'd40);
    fork
      rand_phase(200);
      begin
        repeat (30) @(posedge clk_i);
        hold_out = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_out = 1'b0;
      end
    join
    drain();

    set_code_len(21'($urandom_range(1, 1048576)));
    send_instr(mk(CmdJump, 0, 0, 0, 0, 0));
    rand_phase(200);
    drain();

    idle_on = 1'b0;
    set_code_len(21'd30);
    send_instr(mk(CmdJump, 0, 0, 0, 0, 0));
    rand_phase(180);
    drain();

    $display("covered %0d instructions, %0d result beats checked, six program lengths",
             sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("script_vm_execute_unit_tb OK");
    end else begin
      $display("script_vm_execute_unit_tb NOT OK");
    end
    $finish;
  end
endmodule
